// ----- hw/rtl/pirct_pkg.sv -----
`timescale 1ns / 1ps

package pirct_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int COORD_BITS   = 32;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int DIF_W = COORD_BITS + 1;
   localparam int PRD_W = 2 * DIF_W;
   localparam int CRC_W = 10;

   localparam logic [CRC_W-1:0] COUNT_MAX = CRC_W'(1023);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_VERTICES);

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]                   mode;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic             inside_res;
      logic [CRC_W-1:0] crossing_count;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic             clear_en;
      logic             append_en;
      logic             start;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             diff_en;
      logic             acc_en;
      logic             rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] vertex_count;
   } status_type;

endpackage

// ----- hw/rtl/pirct_ram.sv -----
`timescale 1ns / 1ps

module pirct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pirct_dp.sv -----
`timescale 1ns / 1ps

module pirct_dp import pirct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   localparam int SAT_W = (CNT_W > CRC_W) ? CNT_W : CRC_W;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [CNT_W-1:0] total_ff, total_in;

   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic signed [DIF_W-1:0]      cur_dx_ff, cur_dy_ff, prev_dx_ff, prev_dy_ff;
   logic signed [DIF_W-1:0]      cur_dx_in, cur_dy_in;
   logic signed [PRD_W-1:0]      prod_a_ff, prod_b_ff, prod_a_in, prod_b_in;
   logic                         cross_ff, cross_in, dir_ff, dir_in;
   rsp_type                      rsp_ff, rsp_in;

   logic                  ram_we;
   logic [COORD_BITS-1:0] vx_rd, vy_rd;
   logic                  prev_pos, cur_pos, hit;
   logic [SAT_W-1:0]      total_wide;

   assign ram_we = cmd.append_en && (count_ff < MAX_COUNT);

   pirct_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_x_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data.coord_x),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (vx_rd)
   );

   pirct_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_y_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data.coord_y),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (vy_rd)
   );

   // translate the vertex by the query point, exact in one extra bit
   assign cur_dx_in = $signed({vx_rd[COORD_BITS-1], vx_rd})
                    - $signed({px_ff[COORD_BITS-1], px_ff});
   assign cur_dy_in = $signed({vy_rd[COORD_BITS-1], vy_rd})
                    - $signed({py_ff[COORD_BITS-1], py_ff});

   assign prev_pos = !prev_dy_ff[DIF_W-1] && (|prev_dy_ff);
   assign cur_pos  = !cur_dy_ff[DIF_W-1] && (|cur_dy_ff);

   assign prod_a_in = prev_dx_ff * cur_dy_ff;
   assign prod_b_in = cur_dx_ff * prev_dy_ff;
   assign cross_in  = (prev_pos && !cur_pos) || (cur_pos && !prev_pos);
   assign dir_in    = cur_dy_ff > prev_dy_ff;

   // intercept lies right when sign of the determinant agrees with direction
   assign hit = cross_ff && (prod_a_ff != prod_b_ff) && ((prod_a_ff > prod_b_ff) == dir_ff);

   assign total_wide = SAT_W'(total_ff);

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      total_in    = total_ff;
      rsp_in      = rsp_ff;
      if (cmd.clear_en) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end
      if (cmd.append_en) begin
         if (count_ff < MAX_COUNT) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.start) begin
         total_in = '0;
      end else if (cmd.acc_en && hit) begin
         total_in = total_ff + CNT_W'(1);
      end
      if (cmd.rsp_load) begin
         rsp_in.inside_res     = total_ff[0];
         rsp_in.crossing_count = (total_wide > SAT_W'(COUNT_MAX)) ? COUNT_MAX
                                                                  : total_wide[CRC_W-1:0];
         rsp_in.overflow       = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
      total_ff <= total_in;
      rsp_ff   <= rsp_in;
      if (cmd.start) begin
         px_ff <= req_data.coord_x;
         py_ff <= req_data.coord_y;
      end
      if (cmd.diff_en) begin
         cur_dx_ff  <= cur_dx_in;
         cur_dy_ff  <= cur_dy_in;
         prev_dx_ff <= cur_dx_ff;
         prev_dy_ff <= cur_dy_ff;
      end
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      cross_ff  <= cross_in;
      dir_ff    <= dir_in;
   end

   assign status.vertex_count = count_ff;
   assign rsp_data            = rsp_ff;

endmodule

// ----- hw/rtl/pirct_ctrl.sv -----
`timescale 1ns / 1ps

module pirct_ctrl import pirct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rd_first_ff, rd_first_in;
   logic             seg_b_ff, seg_b_in;
   logic             seg_c_ff, seg_c_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rd_pend_in   = 1'b0;
      rd_first_in  = 1'b0;
      seg_b_in     = rd_pend_ff && !rd_first_ff;
      seg_c_in     = seg_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.rd_addr  = addr_ff[IDX_W-1:0];
      cmd.diff_en  = rd_pend_ff;
      cmd.acc_en   = seg_c_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_CLEAR:  cmd.clear_en  = 1'b1;
                  MODE_APPEND: cmd.append_en = 1'b1;
                  MODE_QUERY: begin
                     cmd.start = 1'b1;
                     addr_in   = '0;
                     state_in  = S_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            // read one vertex a cycle; each after the first closes a segment
            if (addr_ff < status.vertex_count) begin
               cmd.rd_en   = 1'b1;
               rd_pend_in  = 1'b1;
               rd_first_in = (addr_ff == '0);
               addr_in     = addr_ff + CNT_W'(1);
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_pend_ff && !seg_b_ff && !seg_c_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         addr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rd_first_ff  <= 1'b0;
         seg_b_ff     <= 1'b0;
         seg_c_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_pend_ff   <= rd_pend_in;
         rd_first_ff  <= rd_first_in;
         seg_b_ff     <= seg_b_in;
         seg_c_ff     <= seg_c_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/point_in_ring_crossing_test.sv -----
`timescale 1ns / 1ps
// Clear and append items are done as they are accepted; a query's time from accept to
// result grows with vertex_count, set by the single read port of the vertex memory
// streaming one vertex per cycle into a three-stage translate/multiply/compare path.
// One item is in work at a time; a finished result waits in an output register
// while further items are taken. Synchronous reset empties the ring and clears
// the overflow flag; the vertex memory itself is not cleared.

module point_in_ring_crossing_test import pirct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   pirct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pirct_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ----- bench/point_in_ring_crossing_test_tb.sv -----
`timescale 1ns / 1ps

module point_in_ring_crossing_test_tb;
   import pirct_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   // coordinate flavors for random rings
   localparam int STYLE_NARROW = 0;
   localparam int STYLE_WIDE   = 1;
   localparam int STYLE_EDGY   = 2;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   point_in_ring_crossing_test dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   req_type item_q[$];
   rsp_type verdict_q[$];

   // shadow copy of the ring held by the block
   longint ring_x[MAX_VERTICES];
   longint ring_y[MAX_VERTICES];
   int     ring_len = 0;
   bit     ring_ovf = 1'b0;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  req_taken = 1'b0;
   int  mismatches = 0;
   int  items_made = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("point_in_ring_crossing_test regression: fail");
      $finish;
   end

   task automatic apply_to_ring(input req_type it);
      longint             px, py;
      logic signed [67:0] x1, y1, x2, y2, det;
      int                 hits;
      rsp_type            v;
      px = $signed(it.coord_x);
      py = $signed(it.coord_y);
      case (it.mode)
         MODE_CLEAR: begin
            ring_len = 0;
            ring_ovf = 1'b0;
         end
         MODE_APPEND: begin
            if (ring_len < MAX_VERTICES) begin
               ring_x[ring_len] = px;
               ring_y[ring_len] = py;
               ring_len++;
            end else begin
               ring_ovf = 1'b1;
            end
         end
         MODE_QUERY: begin
            hits = 0;
            for (int i = 1; i < ring_len; i++) begin
               x1 = ring_x[i-1] - px;
               y1 = ring_y[i-1] - py;
               x2 = ring_x[i] - px;
               y2 = ring_y[i] - py;
               if ((y1 > 0 && y2 <= 0) || (y2 > 0 && y1 <= 0)) begin
                  det = x1 * y2 - x2 * y1;
                  if ((y2 > y1) ? (det > 0) : (det < 0))
                     hits++;
               end
            end
            v.inside_res     = hits[0];
            v.crossing_count = (hits > int'(COUNT_MAX)) ? COUNT_MAX : CRC_W'(hits);
            v.overflow       = ring_ovf;
            verdict_q.insert(verdict_q.size(), v);
         end
         default: ;
      endcase
   endtask

   // driver: present items at the falling edge, hold until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= item_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
      req_taken = 1'b0;
   end

   // monitor: check results first, then predict the accepted item
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: inside=%0d count=%0d ovf=%0d",
                           rsp_data.inside_res, rsp_data.crossing_count, rsp_data.overflow);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.inside_res !== want.inside_res ||
                   rsp_data.crossing_count !== want.crossing_count ||
                   rsp_data.overflow !== want.overflow) begin
                  if (mismatches < 10)
                     $display("mismatch: expected inside=%0d count=%0d ovf=%0d, got %0d %0d %0d",
                              want.inside_res, want.crossing_count, want.overflow,
                              rsp_data.inside_res, rsp_data.crossing_count,
                              rsp_data.overflow);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            apply_to_ring(req_data);
         end
      end
   end

   task automatic push_item(input logic [1:0] m, input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y);
      req_type it;
      it.mode    = m;
      it.coord_x = x;
      it.coord_y = y;
      item_q.insert(item_q.size(), it);
      if (m != MODE_UNUSED)
         items_made++;
   endtask

   function automatic logic signed [COORD_BITS-1:0] pick_coord(input int style);
      logic signed [COORD_BITS-1:0] c;
      case (style)
         STYLE_NARROW: c = $signed($urandom_range(40)) - 20;
         STYLE_WIDE:   c = $urandom;
         default: begin
            case ($urandom_range(5))
               0: c = C_MIN;
               1: c = C_MAX;
               2: c = '0;
               3: c = -1;
               4: c = 1;
               default: c = $urandom;
            endcase
         end
      endcase
      return c;
   endfunction

   // mostly clear first, build a ring with random content, then query it a few times
   task automatic push_ring_sequence();
      logic signed [COORD_BITS-1:0] sx[16], sy[16];
      int style, n, nq, k;
      case ($urandom_range(19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: style = STYLE_NARROW;
         12, 13, 14, 15, 16: style = STYLE_WIDE;
         default: style = STYLE_EDGY;
      endcase
      n = $urandom_range(12, 2);
      if ($urandom_range(9) != 0)
         push_item(MODE_CLEAR, $urandom, $urandom);
      for (int i = 0; i < n; i++) begin
         // repeat the previous vertex now and then
         if (i > 0 && $urandom_range(9) == 0) begin
            sx[i] = sx[i-1];
            sy[i] = sy[i-1];
         end else begin
            sx[i] = pick_coord(style);
            sy[i] = pick_coord(style);
         end
         push_item(MODE_APPEND, sx[i], sy[i]);
      end
      // close the ring, except for the odd broken one
      if ($urandom_range(9) != 0)
         push_item(MODE_APPEND, sx[0], sy[0]);
      nq = $urandom_range(6, 1);
      for (int q = 0; q < nq; q++) begin
         k = $urandom_range(n - 1);
         case ($urandom_range(3))
            0: push_item(MODE_QUERY, pick_coord(style), sy[k]);
            1: push_item(MODE_QUERY, sx[k], sy[k]);
            default: push_item(MODE_QUERY, pick_coord(style), pick_coord(style));
         endcase
      end
   endtask

   task automatic run_random_phase(input int target);
      int stop_at;
      stop_at = items_made + target;
      while (items_made < stop_at) begin
         if ($urandom_range(9) == 0)
            push_item(2'($urandom_range(3)), $urandom, $urandom);
         else
            push_ring_sequence();
      end
   endtask

   task automatic drain_items();
      @(posedge clock);
      while (item_q.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   initial begin
      send_idle_pct = 27;
      recv_idle_pct = 64;

      // empty ring, then a single vertex: no segments
      push_item(MODE_QUERY, 0, 0);
      push_item(MODE_APPEND, 0, 0);
      push_item(MODE_QUERY, 5, 5);
      // square at the corners of the coordinate range
      push_item(MODE_CLEAR, C_MAX, C_MIN);
      push_item(MODE_APPEND, C_MIN, C_MIN);
      push_item(MODE_APPEND, C_MAX, C_MIN);
      push_item(MODE_APPEND, C_MAX, C_MAX);
      push_item(MODE_APPEND, C_MIN, C_MAX);
      push_item(MODE_APPEND, C_MIN, C_MIN);
      push_item(MODE_QUERY, 0, 0);
      push_item(MODE_QUERY, C_MIN, C_MIN);
      push_item(MODE_QUERY, C_MAX, C_MAX);
      push_item(MODE_QUERY, C_MIN, 0);
      push_item(MODE_QUERY, C_MAX, -1);
      // triangle with a repeated vertex and a horizontal edge
      push_item(MODE_CLEAR, 0, 0);
      push_item(MODE_APPEND, 0, 0);
      push_item(MODE_APPEND, 10, 0);
      push_item(MODE_APPEND, 10, 0);
      push_item(MODE_APPEND, 5, 10);
      push_item(MODE_APPEND, 0, 0);
      push_item(MODE_QUERY, 5, 3);
      push_item(MODE_QUERY, 5, 0);
      // unused mode must leave the ring alone
      push_item(MODE_UNUSED, C_MAX, C_MIN);
      push_item(MODE_QUERY, 5, 10);

      run_random_phase(165);
      drain_items();

      send_idle_pct = 64;
      recv_idle_pct = 27;
      run_random_phase(165);
      drain_items();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(165);
      drain_items();

      @(negedge clock);
      while (verdict_q.size() != 0)
         @(negedge clock);
      repeat (1200) @(negedge clock);

      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("point_in_ring_crossing_test regression: pass");
      end else begin
         $display("point_in_ring_crossing_test regression: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/pirct_pkg.sv
hw/rtl/pirct_ram.sv
hw/rtl/pirct_dp.sv
hw/rtl/pirct_ctrl.sv
hw/rtl/point_in_ring_crossing_test.sv
bench/point_in_ring_crossing_test_tb.sv
